// ----- hw/rtl/multilevel_feedback_scheduler_defines.svh -----
// Assertion macros for the feedback queue scheduler checker.
// Depends on nothing; included by the checker file.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define MFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, disabled in reset
`define MFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ----- hw/rtl/mfs_pkg.sv -----
// Shared codes for the multilevel feedback queue scheduler.
// No dependencies; used by the top level and its checker.
package mfs_pkg;

  // transaction opcodes
  localparam logic [1:0] OP_SUBMIT   = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_REPORT   = 2'd2;

  // result status codes
  localparam logic [3:0] ST_DISPATCHED = 4'd0;
  localparam logic [3:0] ST_REQUEUED   = 4'd1;
  localparam logic [3:0] ST_RETIRED    = 4'd2;
  localparam logic [3:0] ST_ACCEPTED   = 4'd3;
  localparam logic [3:0] ST_HELD       = 4'd4;
  localparam logic [3:0] ST_BAD_LEVEL  = 4'd5;
  localparam logic [3:0] ST_FULL       = 4'd6;
  localparam logic [3:0] ST_EMPTY      = 4'd7;
  localparam logic [3:0] ST_BAD_SEQ    = 4'd8;

endpackage

// ----- hw/rtl/multilevel_feedback_scheduler.sv -----
// Multilevel feedback queue scheduler: level rings and waiting FIFO in sync memories.
// Depends on mfs_pkg.
// Submit is latched and answered from the decode state; dispatch pops one process per result,
// skipping empty levels; report answers each slot, then moves waiting entries into their levels.
// One transaction in flight at a time; the output register frees the input side.
// Synchronous reset clears counts, heads, round state and cpu_count (to 1); memories hold junk.
module multilevel_feedback_scheduler #(
  parameter int LEVEL_DEPTH = 16,
  parameter int WAIT_DEPTH  = 16,
  parameter int MAX_CPUS    = 8,
  parameter int LEVELS      = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [3:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [15:0] proc_id,
  input  logic [3:0]  priority_req,
  input  logic [7:0]  done_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic [15:0] proc_id_res,
  output logic [2:0]  level,
  output logic [2:0]  slot,
  output logic        last
);

  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W  = $clog2(LEVEL_DEPTH);
  localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
  localparam int ADDR_W = $clog2(LEVELS * LEVEL_DEPTH);
  localparam int WPTR_W = $clog2(WAIT_DEPTH);
  localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);
  localparam int SIDX_W = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
  localparam int SCNT_W = $clog2(MAX_CPUS + 1);
  localparam int SUM_W  = $clog2(LEVELS * LEVEL_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_DSEL   = 3'd2;
  localparam logic [2:0] S_DPOP   = 3'd3;
  localparam logic [2:0] S_RSLOT  = 3'd4;
  localparam logic [2:0] S_WREAD  = 3'd5;
  localparam logic [2:0] S_WPUT   = 3'd6;

  // control state
  logic [2:0]        state;
  logic [3:0]        cpu_count;
  logic              round_open;
  logic [PTR_W-1:0]  level_head  [LEVELS];
  logic [CNT_W-1:0]  level_count [LEVELS];
  logic [WCNT_W-1:0] wait_count;
  logic [SCNT_W-1:0] slot_count;
  logic [SCNT_W-1:0] disp_total;
  logic [LVL_W-1:0]  lvl_idx;
  logic [SCNT_W-1:0] sidx;
  logic [WCNT_W-1:0] rd_ptr;
  logic [WCNT_W-1:0] wr_ptr;

  // latched transaction
  logic [1:0]  op_r;
  logic [15:0] pid_r;
  logic [3:0]  prio_r;
  logic [7:0]  done_r;

  // slot store, read at one counter-selected place
  logic [15:0]      slot_pid [MAX_CPUS];
  logic [LVL_W-1:0] slot_lvl [MAX_CPUS];

  // level ring memory
  logic [15:0]       lmem [LEVELS * LEVEL_DEPTH];
  logic              lm_we, lm_re;
  logic [ADDR_W-1:0] lm_waddr, lm_raddr;
  logic [15:0]       lm_wdata, lm_rdata;

  // waiting FIFO memory, entry {level index, id}
  logic [LVL_W+15:0]  wmem [WAIT_DEPTH];
  logic               wm_we, wm_re;
  logic [WPTR_W-1:0]  wm_waddr, wm_raddr;
  logic [LVL_W+15:0]  wm_wdata, wm_rdata;

  function automatic logic [ADDR_W-1:0] laddr(input logic [LVL_W-1:0] li,
                                              input logic [PTR_W-1:0] p);
    laddr = ADDR_W'(int'(li) * LEVEL_DEPTH + int'(p));
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_W'(LEVEL_DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (int'(p) == LEVEL_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_tail(input logic [PTR_W-1:0] h,
                                                input logic [CNT_W-1:0] c);
    logic [PTR_W+1:0] s;
    s = (PTR_W+2)'(h) + (PTR_W+2)'(c);
    ptr_tail = (int'(s) >= LEVEL_DEPTH) ? PTR_W'(s - (PTR_W+2)'(LEVEL_DEPTH)) : PTR_W'(s);
  endfunction

  // derived decode terms
  logic              emit_ok;
  logic              lvl_ok;
  logic [LVL_W-1:0]  sub_li;
  logic [SUM_W-1:0]  avail;
  logic [SCNT_W-1:0] want;
  logic [SCNT_W-1:0] total_c;
  logic [SIDX_W-1:0] si;
  logic [LVL_W-1:0]  rq_li;
  logic [LVL_W-1:0]  wt_li;
  logic              disp_last;
  logic              rep_last;
  logic              slot_done;

  assign emit_ok   = !out_valid || !out_stall;
  assign lvl_ok    = (prio_r != 4'd0) && (int'(prio_r) <= LEVELS);
  assign sub_li    = LVL_W'(prio_r - 4'd1);
  assign si        = SIDX_W'(sidx);
  assign rq_li     = (int'(slot_lvl[si]) == LEVELS - 1) ? slot_lvl[si] : slot_lvl[si] + 1'b1;
  assign wt_li     = wm_rdata[LVL_W+15:16];
  assign disp_last = (slot_count + 1'b1) == disp_total;
  assign rep_last  = (sidx + 1'b1) == slot_count;
  assign slot_done = done_r[3'(sidx)];

  // occupancy sum and dispatch width
  always_comb begin
    avail = '0;
    for (int i = 0; i < LEVELS; i++) begin
      avail = avail + SUM_W'(level_count[i]);
    end
    if (cpu_count == 4'd0) begin
      want = SCNT_W'(1);
    end else if (int'(cpu_count) > MAX_CPUS) begin
      want = SCNT_W'(MAX_CPUS);
    end else begin
      want = SCNT_W'(cpu_count);
    end
    total_c = (int'(avail) < int'(want)) ? SCNT_W'(avail) : want;
  end

  // result generation
  logic        emit;
  logic [3:0]  e_status;
  logic [15:0] e_pid;
  logic [2:0]  e_lvl;
  logic [2:0]  e_slot;
  logic        e_last;

  always_comb begin
    emit     = 1'b0;
    e_status = mfs_pkg::ST_BAD_SEQ;
    e_pid    = '0;
    e_lvl    = '0;
    e_slot   = '0;
    e_last   = 1'b1;
    case (state)
      S_DECODE: begin
        if (op_r == mfs_pkg::OP_SUBMIT) begin
          emit  = 1'b1;
          e_pid = pid_r;
          if (!lvl_ok) begin
            e_status = mfs_pkg::ST_BAD_LEVEL;
          end else if (round_open) begin
            if (int'(wait_count) >= WAIT_DEPTH) begin
              e_status = mfs_pkg::ST_FULL;
            end else begin
              e_status = mfs_pkg::ST_HELD;
              e_lvl    = 3'(prio_r);
            end
          end else if (int'(level_count[sub_li]) >= LEVEL_DEPTH) begin
            e_status = mfs_pkg::ST_FULL;
          end else begin
            e_status = mfs_pkg::ST_ACCEPTED;
            e_lvl    = 3'(prio_r);
          end
        end else if (op_r == mfs_pkg::OP_DISPATCH && !round_open) begin
          if (total_c == '0) begin
            emit     = 1'b1;
            e_status = mfs_pkg::ST_EMPTY;
          end
        end else if (!(op_r == mfs_pkg::OP_REPORT && round_open)) begin
          emit = 1'b1;
        end
      end
      S_DPOP: begin
        emit     = 1'b1;
        e_status = mfs_pkg::ST_DISPATCHED;
        e_pid    = lm_rdata;
        e_lvl    = 3'(lvl_idx) + 3'd1;
        e_slot   = 3'(slot_count);
        e_last   = disp_last;
      end
      S_RSLOT: begin
        emit   = 1'b1;
        e_pid  = slot_pid[si];
        e_slot = 3'(sidx);
        e_last = rep_last;
        if (slot_done) begin
          e_status = mfs_pkg::ST_RETIRED;
        end else if (int'(level_count[rq_li]) >= LEVEL_DEPTH) begin
          e_status = mfs_pkg::ST_FULL;
        end else begin
          e_status = mfs_pkg::ST_REQUEUED;
          e_lvl    = 3'(rq_li) + 3'd1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // memory port selection
  always_comb begin
    lm_we    = 1'b0;
    lm_waddr = '0;
    lm_wdata = pid_r;
    lm_re    = 1'b0;
    lm_raddr = laddr(lvl_idx, level_head[lvl_idx]);
    wm_we    = 1'b0;
    wm_waddr = WPTR_W'(wait_count);
    wm_wdata = {sub_li, pid_r};
    wm_re    = 1'b0;
    wm_raddr = WPTR_W'(rd_ptr);
    case (state)
      S_DECODE: begin
        if (emit_ok && e_status == mfs_pkg::ST_ACCEPTED) begin
          lm_we    = 1'b1;
          lm_waddr = laddr(sub_li, ptr_dec(level_head[sub_li]));
        end
        if (emit_ok && e_status == mfs_pkg::ST_HELD) begin
          wm_we = 1'b1;
        end
      end
      S_DSEL: begin
        lm_re = (level_count[lvl_idx] != '0);
      end
      S_RSLOT: begin
        if (emit_ok && e_status == mfs_pkg::ST_REQUEUED) begin
          lm_we    = 1'b1;
          lm_waddr = laddr(rq_li, ptr_tail(level_head[rq_li], level_count[rq_li]));
          lm_wdata = slot_pid[si];
        end
      end
      S_WREAD: begin
        wm_re = (rd_ptr != wait_count);
      end
      S_WPUT: begin
        if (int'(level_count[wt_li]) >= LEVEL_DEPTH) begin
          wm_we    = 1'b1;
          wm_waddr = WPTR_W'(wr_ptr);
          wm_wdata = wm_rdata;
        end else begin
          lm_we    = 1'b1;
          lm_waddr = laddr(wt_li, ptr_dec(level_head[wt_li]));
          lm_wdata = wm_rdata[15:0];
        end
      end
      default: begin
        lm_we = 1'b0;
      end
    endcase
  end

  // level ring memory
  always_ff @(posedge clk) begin
    if (lm_we) begin
      lmem[lm_waddr] <= lm_wdata;
    end
    if (lm_re) begin
      lm_rdata <= lmem[lm_raddr];
    end
  end

  // waiting FIFO memory
  always_ff @(posedge clk) begin
    if (wm_we) begin
      wmem[wm_waddr] <= wm_wdata;
    end
    if (wm_re) begin
      wm_rdata <= wmem[wm_raddr];
    end
  end

  assign in_stall = (state != S_IDLE);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cpu_count <= 4'd1;
    end else if (cfg_write_en) begin
      cpu_count <= cfg_write_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && emit_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (emit && emit_ok) begin
      status      <= e_status;
      proc_id_res <= e_pid;
      level       <= e_lvl;
      slot        <= e_slot;
      last        <= e_last;
    end
  end

  // transaction latch and slot store
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_r   <= op;
      pid_r  <= proc_id;
      prio_r <= priority_req;
      done_r <= done_mask;
    end
    if (state == S_DPOP && emit_ok) begin
      slot_pid[SIDX_W'(slot_count)] <= lm_rdata;
      slot_lvl[SIDX_W'(slot_count)] <= lvl_idx;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      round_open <= 1'b0;
      wait_count <= '0;
      slot_count <= '0;
      disp_total <= '0;
      lvl_idx    <= '0;
      sidx       <= '0;
      rd_ptr     <= '0;
      wr_ptr     <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        level_head[i]  <= '0;
        level_count[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (op_r == mfs_pkg::OP_SUBMIT) begin
            if (emit_ok) begin
              if (e_status == mfs_pkg::ST_ACCEPTED) begin
                level_head[sub_li]  <= ptr_dec(level_head[sub_li]);
                level_count[sub_li] <= level_count[sub_li] + 1'b1;
              end
              if (e_status == mfs_pkg::ST_HELD) begin
                wait_count <= wait_count + 1'b1;
              end
              state <= S_IDLE;
            end
          end else if (op_r == mfs_pkg::OP_DISPATCH && !round_open) begin
            if (total_c == '0) begin
              if (emit_ok) begin
                state <= S_IDLE;
              end
            end else begin
              slot_count <= '0;
              disp_total <= total_c;
              lvl_idx    <= '0;
              state      <= S_DSEL;
            end
          end else if (op_r == mfs_pkg::OP_REPORT && round_open) begin
            sidx  <= '0;
            state <= S_RSLOT;
          end else if (emit_ok) begin
            state <= S_IDLE;
          end
        end
        S_DSEL: begin
          if (level_count[lvl_idx] == '0) begin
            lvl_idx <= lvl_idx + 1'b1;
          end else begin
            state <= S_DPOP;
          end
        end
        S_DPOP: begin
          if (emit_ok) begin
            level_head[lvl_idx]  <= ptr_inc(level_head[lvl_idx]);
            level_count[lvl_idx] <= level_count[lvl_idx] - 1'b1;
            slot_count           <= slot_count + 1'b1;
            if (disp_last) begin
              round_open <= 1'b1;
              state      <= S_IDLE;
            end else begin
              state <= S_DSEL;
            end
          end
        end
        S_RSLOT: begin
          if (emit_ok) begin
            if (e_status == mfs_pkg::ST_REQUEUED) begin
              level_count[rq_li] <= level_count[rq_li] + 1'b1;
            end
            sidx <= sidx + 1'b1;
            if (rep_last) begin
              rd_ptr <= '0;
              wr_ptr <= '0;
              state  <= S_WREAD;
            end
          end
        end
        S_WREAD: begin
          if (rd_ptr == wait_count) begin
            wait_count <= wr_ptr;
            slot_count <= '0;
            round_open <= 1'b0;
            state      <= S_IDLE;
          end else begin
            state <= S_WPUT;
          end
        end
        S_WPUT: begin
          if (int'(level_count[wt_li]) >= LEVEL_DEPTH) begin
            wr_ptr <= wr_ptr + 1'b1;
          end else begin
            level_head[wt_li]  <= ptr_dec(level_head[wt_li]);
            level_count[wt_li] <= level_count[wt_li] + 1'b1;
          end
          rd_ptr <= rd_ptr + 1'b1;
          state  <= S_WREAD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/mfs_checker.sv -----
// Port-level checker for the feedback queue scheduler, with its bind.
// Depends on mfs_pkg and multilevel_feedback_scheduler_defines.svh.
`include "multilevel_feedback_scheduler_defines.svh"

module mfs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  status,
  input logic [2:0]  level,
  input logic        last
);

  // a held result stays offered
  `MFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // an accepted transaction blocks the input side on the next cycle
  `MFS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // single-result statuses always close their transaction
  `MFS_ASSERT_NOW(a_single_last, out_valid && (status == mfs_pkg::ST_ACCEPTED || status == mfs_pkg::ST_HELD || status == mfs_pkg::ST_BAD_LEVEL || status == mfs_pkg::ST_EMPTY || status == mfs_pkg::ST_BAD_SEQ), last)

  // retired and rejected processes report no level
  `MFS_ASSERT_NOW(a_no_level, out_valid && (status == mfs_pkg::ST_RETIRED || status == mfs_pkg::ST_FULL || status == mfs_pkg::ST_BAD_SEQ), level == 3'd0)

endmodule

bind multilevel_feedback_scheduler mfs_checker u_mfs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .level     (level),
  .last      (last)
);
